>>> hw/rtl/mbup_pkg.sv
// shared types and constants for the midi byte to usb event packer
package mbup_pkg;

    // expected message length codes
    localparam logic [2:0] LEN_NONE  = 3'd0;
    localparam logic [2:0] LEN_TWO   = 3'd2;
    localparam logic [2:0] LEN_THREE = 3'd3;
    localparam logic [2:0] LEN_SYSEX = 3'd7;

    // usb-midi code index numbers
    localparam logic [3:0] CIN_COMMON2  = 4'h2;
    localparam logic [3:0] CIN_COMMON3  = 4'h3;
    localparam logic [3:0] CIN_SYSEX    = 4'h4;
    localparam logic [3:0] CIN_END1     = 4'h5;
    localparam logic [3:0] CIN_END2     = 4'h6;
    localparam logic [3:0] CIN_END3     = 4'h7;
    localparam logic [3:0] CIN_SINGLE   = 4'hF;

    // special status bytes
    localparam logic [7:0] ST_SYSEX_START = 8'hF0;
    localparam logic [7:0] ST_EOX         = 8'hF7;

    // converter state carried between bytes
    typedef struct packed {
        logic [7:0] last_status;
        logic [2:0] exp_len;
        logic [1:0] byte_count;
        logic [3:0] hdr_cin;
        logic [3:0] hdr_cable;
        logic [7:0] mb0;
        logic [7:0] mb1;
        logic [7:0] mb2;
    } conv_state_t;

    // one usb-midi event packet
    typedef struct packed {
        logic [3:0] cin;
        logic [3:0] cable;
        logic [7:0] b1;
        logic [7:0] b2;
        logic [7:0] b3;
    } event_pkt_t;

endpackage

>>> hw/rtl/mbup_in_reg.sv
// input register holding one received midi byte
module mbup_in_reg (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] rx_byte,
    input  logic       take,
    output logic       held_valid,
    output logic [7:0] held_byte
);

    logic       valid_reg;
    logic [7:0] byte_reg;

    // accept a new word when empty or when the held one is consumed
    assign in_ready   = !valid_reg || take;
    assign held_valid = valid_reg;
    assign held_byte  = byte_reg;

    // valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    // byte payload
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            byte_reg <= rx_byte;
        end
    end

endmodule

>>> hw/rtl/mbup_decode.sv
// per-byte decode: next converter state and packet emission
module mbup_decode (
    input  mbup_pkg::conv_state_t cur,
    input  logic [7:0]            rx_byte,
    input  logic [3:0]            cable_cfg,
    output mbup_pkg::conv_state_t nxt,
    output logic                  emit,
    output mbup_pkg::event_pkt_t  pkt
);

    // start a new message with the just-stored status byte
    function automatic mbup_pkg::conv_state_t open_msg(
        input mbup_pkg::conv_state_t s,
        input logic [3:0]            cin,
        input logic [2:0]            len,
        input logic [3:0]            cbl
    );
        mbup_pkg::conv_state_t r;
        r            = s;
        r.hdr_cin    = cin;
        r.hdr_cable  = cbl;
        r.mb0        = s.last_status;
        r.mb1        = 8'h00;
        r.mb2        = 8'h00;
        r.byte_count = 2'd1;
        r.exp_len    = len;
        return r;
    endfunction

    logic [1:0] cnt;

    always_comb
    begin
        nxt  = cur;
        emit = 1'b0;
        cnt  = cur.byte_count;
        if (rx_byte[7])
        begin
            // status byte
            nxt.last_status = rx_byte;
            case (rx_byte[7:4]) inside
                4'h8, 4'h9, 4'hA, 4'hB, 4'hE:
                begin
                    nxt = open_msg(nxt, rx_byte[7:4], mbup_pkg::LEN_THREE, cable_cfg);
                end
                4'hC, 4'hD:
                begin
                    nxt = open_msg(nxt, rx_byte[7:4], mbup_pkg::LEN_TWO, cable_cfg);
                end
                default:
                begin
                    case (rx_byte) inside
                        8'hF8, 8'hFA, 8'hFB, 8'hFC, 8'hFE, 8'hFF:
                        begin
                            nxt  = open_msg(nxt, mbup_pkg::CIN_SINGLE, mbup_pkg::LEN_NONE,
                                            cable_cfg);
                            emit = 1'b1;
                        end
                        8'hF2:
                        begin
                            nxt = open_msg(nxt, mbup_pkg::CIN_COMMON3, mbup_pkg::LEN_THREE,
                                           cable_cfg);
                        end
                        8'hF1, 8'hF3:
                        begin
                            nxt = open_msg(nxt, mbup_pkg::CIN_COMMON2, mbup_pkg::LEN_TWO,
                                           cable_cfg);
                        end
                        8'hF6:
                        begin
                            nxt  = open_msg(nxt, mbup_pkg::CIN_END1, mbup_pkg::LEN_NONE,
                                            cable_cfg);
                            emit = 1'b1;
                        end
                        mbup_pkg::ST_SYSEX_START:
                        begin
                            nxt.mb0        = mbup_pkg::ST_SYSEX_START;
                            nxt.mb1        = 8'h00;
                            nxt.mb2        = 8'h00;
                            nxt.byte_count = 2'd1;
                            nxt.exp_len    = mbup_pkg::LEN_SYSEX;
                        end
                        mbup_pkg::ST_EOX:
                        begin
                            nxt.hdr_cable = cable_cfg;
                            nxt.exp_len   = mbup_pkg::LEN_NONE;
                            emit          = 1'b1;
                            if (cur.exp_len == mbup_pkg::LEN_SYSEX && cur.byte_count == 2'd1)
                            begin
                                nxt.hdr_cin = mbup_pkg::CIN_END2;
                                nxt.mb1     = mbup_pkg::ST_EOX;
                                nxt.mb2     = 8'h00;
                            end
                            else if (cur.exp_len == mbup_pkg::LEN_SYSEX
                                     && cur.byte_count == 2'd2)
                            begin
                                nxt.hdr_cin = mbup_pkg::CIN_END3;
                                nxt.mb2     = mbup_pkg::ST_EOX;
                            end
                            else
                            begin
                                // eox with nothing to close
                                nxt.hdr_cin = mbup_pkg::CIN_END1;
                                nxt.mb0     = mbup_pkg::ST_EOX;
                                nxt.mb1     = 8'h00;
                                nxt.mb2     = 8'h00;
                            end
                        end
                        default:
                        begin
                            // undefined status closes the open message
                            nxt.exp_len = mbup_pkg::LEN_NONE;
                        end
                    endcase
                end
            endcase
        end
        else if (cur.exp_len == mbup_pkg::LEN_TWO || cur.exp_len == mbup_pkg::LEN_THREE)
        begin
            // data byte of a channel or system common message, running status
            if (cnt == 2'd0)
            begin
                nxt.hdr_cin   = cur.last_status[7:4];
                nxt.hdr_cable = cable_cfg;
                nxt.mb0       = cur.last_status;
                cnt           = 2'd1;
            end
            if ({1'b0, cnt} < cur.exp_len)
            begin
                case (cnt)
                    2'd1:    nxt.mb1 = rx_byte;
                    2'd2:    nxt.mb2 = rx_byte;
                    default: nxt.mb0 = rx_byte;
                endcase
                cnt = cnt + 2'd1;
            end
            if ({1'b0, cnt} == cur.exp_len)
            begin
                cnt  = 2'd0;
                emit = 1'b1;
            end
            nxt.byte_count = cnt;
        end
        else if (cur.exp_len == mbup_pkg::LEN_SYSEX)
        begin
            // sysex payload, three bytes per packet
            cnt = cnt + 2'd1;
            case (cnt)
                2'd1:    nxt.mb0 = rx_byte;
                2'd2:    nxt.mb1 = rx_byte;
                2'd3:    nxt.mb2 = rx_byte;
                default: nxt.mb0 = cur.mb0;
            endcase
            if (cnt == 2'd3)
            begin
                nxt.hdr_cin   = mbup_pkg::CIN_SYSEX;
                nxt.hdr_cable = cable_cfg;
                cnt           = 2'd0;
                emit          = 1'b1;
            end
            nxt.byte_count = cnt;
        end
    end

    // packet taken from the updated state
    assign pkt.cin   = nxt.hdr_cin;
    assign pkt.cable = nxt.hdr_cable;
    assign pkt.b1    = nxt.mb0;
    assign pkt.b2    = nxt.mb1;
    assign pkt.b3    = nxt.mb2;

endmodule

>>> hw/rtl/midi_byte_to_usb_event_packer_core.sv
// path: a byte accepted into the input register is decoded, and its packet word
//   is stored in the packet register; while that is full and unread, the byte waits
// throughput: one byte per cycle while the packet register is empty or being read,
//   set by the single decode stage between the input register and the packet register
// reset: no message open, byte count zero, cable number zero, both
//   registers empty; the block takes words at once after reset
module midi_byte_to_usb_event_packer_core (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [3:0] cable_number,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] rx_byte,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [3:0] code_index,
    output logic [3:0] cable,
    output logic [7:0] msg_byte1,
    output logic [7:0] msg_byte2,
    output logic [7:0] msg_byte3
);

    logic                  held_valid;
    logic [7:0]            held_byte;
    logic                  take;
    logic                  emit;
    logic [3:0]            cable_reg;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    mbup_pkg::conv_state_t state_reg;
    mbup_pkg::conv_state_t state_next;
    mbup_pkg::event_pkt_t  pkt;
    mbup_pkg::event_pkt_t  pkt_reg;

    // process the held byte when the packet register can take a result
    assign take = held_valid && (!out_valid_reg || out_ready);

    mbup_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .rx_byte    (rx_byte),
        .take       (take),
        .held_valid (held_valid),
        .held_byte  (held_byte)
    );

    mbup_decode u_decode (
        .cur       (state_reg),
        .rx_byte   (held_byte),
        .cable_cfg (cable_reg),
        .nxt       (state_next),
        .emit      (emit),
        .pkt       (pkt)
    );

    // cable number register
    assign cfg_ready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cable_reg <= 4'h0;
        end
        else if (cfg_valid)
        begin
            cable_reg <= cable_number;
        end
    end

    // converter state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
        end
        else if (take)
        begin
            state_reg <= state_next;
        end
    end

    // packet register valid
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (take)
        begin
            out_valid_next = emit;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // packet payload
    always_ff @(posedge clk)
    begin
        if (take && emit)
        begin
            pkt_reg <= pkt;
        end
    end

    assign out_valid  = out_valid_reg;
    assign code_index = pkt_reg.cin;
    assign cable      = pkt_reg.cable;
    assign msg_byte1  = pkt_reg.b1;
    assign msg_byte2  = pkt_reg.b2;
    assign msg_byte3  = pkt_reg.b3;

endmodule
